>>> rtl/core/htpi_pkg.sv
`timescale 1ns / 1ps

package htpi_pkg;

  // Fixed field widths
  localparam int KEY_W   = 32;
  localparam int SLOT_W  = 7;
  localparam int COUNT_W = 6;

  // Defaults for the top-level parameters
  localparam int TABLE_SIZE_DEF = 97;
  localparam int MAX_PROBES_DEF = 48;

  // Hash mixing multiplier
  localparam logic [KEY_W-1:0] MIX_MUL = 32'h045d_9f3b;

  // Depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  // One result beat
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] probe_count;
    logic               table_full;
  } res_t;

endpackage

>>> rtl/core/htpi_front.sv
`timescale 1ns / 1ps

module htpi_front #(
  parameter int TABLE_SIZE = htpi_pkg::TABLE_SIZE_DEF,
  parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic [htpi_pkg::KEY_W-1:0] in_key,
  output logic                       in_full,
  input  logic                       clearing,
  output logic                       q_push,
  output logic [htpi_pkg::KEY_W-1:0] q_key,
  output logic [IDX_W-1:0]           q_home,
  input  logic                       q_full
);

  localparam int KW = htpi_pkg::KEY_W;
  // floor(2^32 / TABLE_SIZE): quotient estimate is low by at most one
  localparam logic [KW-1:0]  RECIP = KW'((64'd1 << KW) / TABLE_SIZE);
  localparam logic [KW-1:0]  TS32  = KW'(TABLE_SIZE);
  localparam logic [IDX_W:0] TS_N  = (IDX_W+1)'(TABLE_SIZE);

  logic          v1_r, v2_r, v3_r, v4_r;
  logic [KW-1:0] p1_r, p2_r, h3_r, qe3_r, h4_r, prod4_r;
  logic [KW-1:0] key1_r, key2_r, key3_r, key4_r;
  logic          adv, accept;
  logic [KW-1:0] x1, x2, h3_nxt;
  logic [2*KW-1:0] qe_wide;
  logic [KW-1:0] rem;
  logic [IDX_W:0] rem_n;

  // The whole pipeline holds when its last stage cannot drain
  assign adv     = !(v4_r && q_full);
  assign in_full = !adv || clearing;
  assign accept  = in_push && !in_full;

  assign x1      = (in_key >> 16) ^ in_key;
  assign x2      = (p1_r >> 16) ^ p1_r;
  assign h3_nxt  = (p2_r >> 16) ^ p2_r;
  assign qe_wide = {{KW{1'b0}}, h3_nxt} * {{KW{1'b0}}, RECIP};

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Mix rounds, then reciprocal estimate of the quotient
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= KW'(x1 * htpi_pkg::MIX_MUL);
      p2_r    <= KW'(x2 * htpi_pkg::MIX_MUL);
      h3_r    <= h3_nxt;
      qe3_r   <= qe_wide[2*KW-1:KW];
      h4_r    <= h3_r;
      prod4_r <= KW'(qe3_r * TS32);
    end
  end

  // Remainder is below twice the table size: one correction step
  assign rem    = h4_r - prod4_r;
  assign rem_n  = rem[IDX_W:0];
  assign q_home = (rem_n >= TS_N) ? IDX_W'(rem_n - TS_N) : IDX_W'(rem_n);
  assign q_key  = key4_r;

  // Carry the key alongside the hash
  always_ff @(posedge clk) begin
    if (adv) begin
      key1_r <= in_key;
      key2_r <= key1_r;
      key3_r <= key2_r;
      key4_r <= key3_r;
    end
  end

  assign q_push = v4_r && !q_full;

endmodule

>>> rtl/core/htpi_queue.sv
`timescale 1ns / 1ps

module htpi_queue #(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output logic              empty
);

  localparam int DEPTH = htpi_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] buf_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]    count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == (PTR_W+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = buf_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) buf_r[wr_ptr_r] <= wr_data;
  end

endmodule

>>> rtl/core/htpi_back.sv
`timescale 1ns / 1ps

module htpi_back #(
  parameter int TABLE_SIZE = htpi_pkg::TABLE_SIZE_DEF,
  parameter int MAX_PROBES = htpi_pkg::MAX_PROBES_DEF,
  parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic [htpi_pkg::KEY_W-1:0] q_key,
  input  logic [IDX_W-1:0]           q_home,
  output logic                       clearing,
  output logic                       out_empty,
  input  logic                       out_pop,
  output htpi_pkg::res_t             out_res
);

  localparam int Q_W = $clog2(MAX_PROBES + 1);
  localparam logic [IDX_W:0]   TS_N    = (IDX_W+1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(TABLE_SIZE - 1);
  localparam logic [Q_W-1:0]   Q_LIMIT = Q_W'(MAX_PROBES);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [IDX_W-1:0]           clr_idx_r;
  logic [IDX_W-1:0]           home_r, pos_r, off_r, pos_nxt, off_nxt;
  logic [Q_W-1:0]             q_r;
  logic [htpi_pkg::KEY_W-1:0] key_r;
  logic                       occ_rd_r;
  logic                       out_valid_r;
  htpi_pkg::res_t             out_res_r;

  logic                       occ_mem [TABLE_SIZE];
  logic [htpi_pkg::KEY_W-1:0] key_mem [TABLE_SIZE];

  logic [IDX_W:0]   off2, pos_sum;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             wr_en, wr_bit;
  logic             resolved, out_free, emit, step;

  // Next probe offset (2^q mod size) and position
  assign off2    = {off_r, 1'b0};
  assign off_nxt = (off2 >= TS_N) ? IDX_W'(off2 - TS_N) : IDX_W'(off2);
  assign pos_sum = {1'b0, home_r} + {1'b0, off_nxt};
  assign pos_nxt = (pos_sum >= TS_N) ? IDX_W'(pos_sum - TS_N) : IDX_W'(pos_sum);

  assign out_free = !out_valid_r || out_pop;
  assign resolved = !occ_rd_r || (q_r == Q_LIMIT);
  assign emit     = (state_r == ST_PROBE) && resolved && out_free;
  assign step     = (state_r == ST_PROBE) && !resolved;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign clearing = (state_r == ST_CLEAR);

  // Select read address: new home, next probe, or hold current
  always_comb begin
    rd_addr = pos_r;
    if (state_r == ST_IDLE) rd_addr = q_home;
    else if (step)          rd_addr = pos_nxt;
  end

  // Select write: clearing sweep or claim of the free slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_bit  = 1'b1;
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_bit  = 1'b0;
    end else if (emit && !occ_rd_r) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_idx_r == LAST) state_nxt = ST_IDLE;
      ST_IDLE:  if (!q_empty) state_nxt = ST_PROBE;
      ST_PROBE: if (emit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
      if (emit)         out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  // Probe walk registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      home_r <= q_home;
      key_r  <= q_key;
      pos_r  <= q_home;
      off_r  <= IDX_W'(1);
      q_r    <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      off_r <= off_nxt;
      q_r   <= q_r + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r.table_full  <= occ_rd_r;
      out_res_r.slot        <= occ_rd_r ? '0 : htpi_pkg::SLOT_W'(pos_r);
      out_res_r.probe_count <= htpi_pkg::COUNT_W'(q_r);
    end
  end

  // Occupancy map: one read, one write per cycle
  always_ff @(posedge clk) begin
    occ_rd_r <= occ_mem[rd_addr];
    if (wr_en) occ_mem[wr_addr] <= wr_bit;
  end

  // Key store
  always_ff @(posedge clk) begin
    if (emit && !occ_rd_r) key_mem[pos_r] <= key_r;
  end

  assign out_empty = !out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> rtl/core/hash_table_probe_insert.sv
`timescale 1ns / 1ps

// Channel | Ports                                           | Beat taken when
// input   | in_push, in_full, in_key                        | in_push & !in_full
// result  | out_empty, out_pop, out_slot, out_probe_count,  | out_pop & !out_empty
//         | out_table_full                                  |
//
// Front: four-stage hash and modulo pipeline, one key per cycle while the
// queue has room and no clearing runs, into a four-entry queue. Back: the
// idle state pops an item and reads its home slot; the probe state then
// walks the occupancy memory to a free slot or the probe limit. After reset
// a clearing sweep empties every slot with in_full high. A result waiting in
// the output register stalls only the back; the front keeps taking keys until the queue fills.

module hash_table_probe_insert #(
  parameter int TABLE_SIZE = htpi_pkg::TABLE_SIZE_DEF,
  parameter int MAX_PROBES = htpi_pkg::MAX_PROBES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic [htpi_pkg::KEY_W-1:0]     in_key,
  output logic                           in_full,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [htpi_pkg::SLOT_W-1:0]    out_slot,
  output logic [htpi_pkg::COUNT_W-1:0]   out_probe_count,
  output logic                           out_table_full
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int QW    = htpi_pkg::KEY_W + IDX_W;

  logic                       fq_push, fq_full, fq_pop, fq_empty, clearing;
  logic [htpi_pkg::KEY_W-1:0] fq_key, bq_key;
  logic [IDX_W-1:0]           fq_home, bq_home;
  htpi_pkg::res_t             res;

  htpi_front #(.TABLE_SIZE(TABLE_SIZE), .IDX_W(IDX_W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_key   (in_key),
    .in_full  (in_full),
    .clearing (clearing),
    .q_push   (fq_push),
    .q_key    (fq_key),
    .q_home   (fq_home),
    .q_full   (fq_full)
  );

  htpi_queue #(.DATA_W(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_data ({fq_key, fq_home}),
    .full    (fq_full),
    .pop     (fq_pop),
    .rd_data ({bq_key, bq_home}),
    .empty   (fq_empty)
  );

  htpi_back #(.TABLE_SIZE(TABLE_SIZE), .MAX_PROBES(MAX_PROBES), .IDX_W(IDX_W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (fq_empty),
    .q_pop     (fq_pop),
    .q_key     (bq_key),
    .q_home    (bq_home),
    .clearing  (clearing),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  assign out_slot        = res.slot;
  assign out_probe_count = res.probe_count;
  assign out_table_full  = res.table_full;

endmodule

>>> rtl/core/htpi_checker.sv
`timescale 1ns / 1ps

module htpi_checker #(
  parameter int TABLE_SIZE = htpi_pkg::TABLE_SIZE_DEF,
  parameter int MAX_PROBES = htpi_pkg::MAX_PROBES_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_push,
  input logic                         in_full,
  input logic                         out_empty,
  input logic                         out_pop,
  input logic [htpi_pkg::SLOT_W-1:0]  out_slot,
  input logic [htpi_pkg::COUNT_W-1:0] out_probe_count,
  input logic                         out_table_full
);

  localparam logic [htpi_pkg::COUNT_W-1:0] LIMIT = htpi_pkg::COUNT_W'(MAX_PROBES);

  // The clearing sweep blocks input right after reset
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input open right after reset");

  // No result appears out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present right after reset");

  // A full-table result carries slot zero and the probe limit
  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_table_full) |-> (out_slot == '0 && out_probe_count == LIMIT))
    else $error("table_full result has wrong fields");

  // A placed key lands inside the table within the probe limit
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_table_full) |->
      ((TABLE_SIZE > 128 || int'(out_slot) < TABLE_SIZE) && out_probe_count <= LIMIT))
    else $error("placed result out of range");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_slot) && $stable(out_probe_count) && $stable(out_table_full)))
    else $error("result changed while waiting");

endmodule

bind hash_table_probe_insert htpi_checker #(
  .TABLE_SIZE(TABLE_SIZE),
  .MAX_PROBES(MAX_PROBES)
) u_htpi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_push         (in_push),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_slot        (out_slot),
  .out_probe_count (out_probe_count),
  .out_table_full  (out_table_full)
);
